FILE: rtl/lpr_pkg.sv
// Shared types and constants of the LRU page replacement block.
package lpr_pkg;

    // Default sizing of the frame table
    localparam int LPR_MAX_FRAMES = 8;
    localparam int LPR_PAGE_BITS  = 16;

    // Fixed field widths of the stream payloads
    localparam int LPR_PAGE_W   = 16;
    localparam int LPR_FRAMES_W = 4;
    localparam int LPR_FIDX_W   = 3;
    localparam int LPR_COUNT_W  = 32;
    localparam int LPR_RES_W    = 1 + LPR_FIDX_W + 1 + LPR_PAGE_W + LPR_COUNT_W;
    localparam int LPR_M_DATA_W = ((LPR_RES_W + 7) / 8) * 8;

    // Frame count after reset
    localparam logic [LPR_FRAMES_W-1:0] LPR_FRAMES_RESET = 4'd3;

    // One result beat, hit in the lowest bit
    typedef struct packed {
        logic [LPR_COUNT_W-1:0] fault_count;
        logic [LPR_PAGE_W-1:0]  evicted_page;
        logic                   evicted_valid;
        logic [LPR_FIDX_W-1:0]  frame_index;
        logic                   hit;
    } lpr_result_t;

    // Sequencer status toward the stream ports
    typedef struct packed {
        logic idle;
        logic res_valid;
    } lpr_status_t;

endpackage

FILE: rtl/lpr_frame_mem.sv
// Frame table memory: one write port, one registered read port.
module lpr_frame_mem import lpr_pkg::*; #(
    parameter int DEPTH  = LPR_MAX_FRAMES,
    parameter int ADDR_W = 3,
    parameter int DATA_W = 19
) (
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered output
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/lpr_ctrl.sv
// Sequencer: scans the frame table, picks hit or victim, then ages ranks.
module lpr_ctrl import lpr_pkg::*; #(
    parameter int MAX_FRAMES = LPR_MAX_FRAMES,
    parameter int PAGE_BITS  = LPR_PAGE_BITS,
    parameter int IDX_W      = 3,
    parameter int ENTRY_W    = 19
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [LPR_PAGE_W-1:0]    start_page,
    input  logic                     start_first,
    input  logic [LPR_FRAMES_W-1:0]  frames_in_use,
    output lpr_status_t              status,
    input  logic                     res_ready,
    output lpr_result_t              result,
    output logic                     mem_rd_en,
    output logic [IDX_W-1:0]         mem_rd_addr,
    input  logic [ENTRY_W-1:0]       mem_rdata,
    output logic                     mem_wr_en,
    output logic [IDX_W-1:0]         mem_wr_addr,
    output logic [ENTRY_W-1:0]       mem_wdata
);

    localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
    localparam int RANK_W = IDX_W;
    localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_FRAMES - 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_AGE  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    logic [MAX_FRAMES-1:0]  valid_reg, valid_next;
    logic [CNT_W-1:0]       filled_reg, filled_next;
    logic [LPR_COUNT_W-1:0] faults_reg, faults_next;
    logic                   rsp_vld_reg, rsp_vld_next;

    logic [PAGE_BITS-1:0]   page_reg, page_next;
    logic [CNT_W-1:0]       active_reg, active_next;
    logic [CNT_W-1:0]       rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]       rsp_idx_reg, rsp_idx_next;
    logic                   hit_found_reg, hit_found_next;
    logic [IDX_W-1:0]       hit_idx_reg, hit_idx_next;
    logic [RANK_W-1:0]      hit_rank_reg, hit_rank_next;
    logic                   vic_found_reg, vic_found_next;
    logic [IDX_W-1:0]       vic_idx_reg, vic_idx_next;
    logic [RANK_W-1:0]      vic_rank_reg, vic_rank_next;
    logic [PAGE_BITS-1:0]   vic_page_reg, vic_page_next;
    logic [IDX_W-1:0]       sel_reg, sel_next;
    logic                   age_all_reg, age_all_next;
    logic                   ev_valid_reg, ev_valid_next;

    logic [PAGE_BITS+LPR_PAGE_W-1:0] page_in_ext;
    logic [PAGE_BITS+LPR_PAGE_W-1:0] vic_page_ext;
    logic [IDX_W+LPR_FIDX_W-1:0]     sel_ext;
    logic [CNT_W-1:0]                start_active;
    logic                            issue;
    logic [RANK_W-1:0]               rsp_rank;
    logic [PAGE_BITS-1:0]            rsp_page;
    logic                            rsp_v;
    logic                            pass_done;
    logic                            age_it;

    // Fit the incoming page to the stored width
    assign page_in_ext = {{PAGE_BITS{1'b0}}, start_page};

    // Clamp the frame count into 1..MAX_FRAMES
    always_comb begin
        if (frames_in_use == '0) begin
            start_active = CNT_W'(1);
        end else if (32'(frames_in_use) > MAX_FRAMES) begin
            start_active = CNT_W'(MAX_FRAMES);
        end else begin
            start_active = CNT_W'(frames_in_use);
        end
    end

    // Split the returning table entry
    assign rsp_rank  = mem_rdata[ENTRY_W-1:PAGE_BITS];
    assign rsp_page  = mem_rdata[PAGE_BITS-1:0];
    assign rsp_v     = valid_reg[rsp_idx_reg];
    assign issue     = (state_reg == ST_SCAN || state_reg == ST_AGE) && (rd_idx_reg < active_reg);
    assign pass_done = !issue && !rsp_vld_reg;
    assign age_it    = rsp_v && (age_all_reg || rsp_rank < hit_rank_reg) && (rsp_rank < RANK_MAX);

    // Next-state logic of the sequencer
    always_comb begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        filled_next    = filled_reg;
        faults_next    = faults_reg;
        rsp_vld_next   = issue;
        page_next      = page_reg;
        active_next    = active_reg;
        rd_idx_next    = rd_idx_reg;
        rsp_idx_next   = rd_idx_reg[IDX_W-1:0];
        hit_found_next = hit_found_reg;
        hit_idx_next   = hit_idx_reg;
        hit_rank_next  = hit_rank_reg;
        vic_found_next = vic_found_reg;
        vic_idx_next   = vic_idx_reg;
        vic_rank_next  = vic_rank_reg;
        vic_page_next  = vic_page_reg;
        sel_next       = sel_reg;
        age_all_next   = age_all_reg;
        ev_valid_next  = ev_valid_reg;
        mem_rd_en      = issue;
        mem_rd_addr    = rd_idx_reg[IDX_W-1:0];
        mem_wr_en      = 1'b0;
        mem_wr_addr    = rsp_idx_reg;
        mem_wdata      = mem_rdata;

        if (issue) begin
            rd_idx_next = rd_idx_reg + CNT_W'(1);
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    page_next      = page_in_ext[PAGE_BITS-1:0];
                    active_next    = start_active;
                    rd_idx_next    = '0;
                    hit_found_next = 1'b0;
                    vic_found_next = 1'b0;
                    ev_valid_next  = 1'b0;
                    state_next     = ST_SCAN;
                    // Start of a new sequence: empty the frames first
                    if (start_first) begin
                        valid_next  = '0;
                        filled_next = '0;
                        faults_next = '0;
                    end
                end
            end

            ST_SCAN: begin
                // Track the first matching frame and the oldest valid frame
                if (rsp_vld_reg) begin
                    if (rsp_v && rsp_page == page_reg && !hit_found_reg) begin
                        hit_found_next = 1'b1;
                        hit_idx_next   = rsp_idx_reg;
                        hit_rank_next  = rsp_rank;
                    end
                    if (rsp_v && (!vic_found_reg || rsp_rank > vic_rank_reg)) begin
                        vic_found_next = 1'b1;
                        vic_idx_next   = rsp_idx_reg;
                        vic_rank_next  = rsp_rank;
                        vic_page_next  = rsp_page;
                    end
                end
                // Pick the frame once every entry has come back
                if (pass_done) begin
                    rd_idx_next = '0;
                    state_next  = ST_AGE;
                    if (hit_found_reg) begin
                        sel_next     = hit_idx_reg;
                        age_all_next = 1'b0;
                    end else begin
                        age_all_next = 1'b1;
                        if (filled_reg < active_reg) begin
                            sel_next    = filled_reg[IDX_W-1:0];
                            filled_next = filled_reg + CNT_W'(1);
                        end else if (vic_found_reg) begin
                            sel_next      = vic_idx_reg;
                            ev_valid_next = 1'b1;
                        end else begin
                            sel_next = '0;
                        end
                        valid_next[sel_next] = 1'b1;
                        if (faults_reg != '1) begin
                            faults_next = faults_reg + LPR_COUNT_W'(1);
                        end
                    end
                end
            end

            ST_AGE: begin
                // Write back all entries: chosen to rank zero, others may age
                if (rsp_vld_reg) begin
                    mem_wr_en = 1'b1;
                    if (rsp_idx_reg == sel_reg) begin
                        mem_wdata = {{RANK_W{1'b0}}, hit_found_reg ? rsp_page : page_reg};
                    end else if (age_it) begin
                        mem_wdata = {rsp_rank + RANK_W'(1), rsp_page};
                    end
                end
                if (pass_done) begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            filled_reg  <= '0;
            faults_reg  <= '0;
            rsp_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            filled_reg  <= filled_next;
            faults_reg  <= faults_next;
            rsp_vld_reg <= rsp_vld_next;
        end
    end

    // Working registers of the current reference
    always_ff @(posedge aclk) begin
        page_reg      <= page_next;
        active_reg    <= active_next;
        rd_idx_reg    <= rd_idx_next;
        rsp_idx_reg   <= rsp_idx_next;
        hit_found_reg <= hit_found_next;
        hit_idx_reg   <= hit_idx_next;
        hit_rank_reg  <= hit_rank_next;
        vic_found_reg <= vic_found_next;
        vic_idx_reg   <= vic_idx_next;
        vic_rank_reg  <= vic_rank_next;
        vic_page_reg  <= vic_page_next;
        sel_reg       <= sel_next;
        age_all_reg   <= age_all_next;
        ev_valid_reg  <= ev_valid_next;
    end

    // Result fields, evicted page zero when nothing was replaced
    assign vic_page_ext = {{LPR_PAGE_W{1'b0}}, vic_page_reg};
    assign sel_ext      = {{LPR_FIDX_W{1'b0}}, sel_reg};

    always_comb begin
        result.hit           = hit_found_reg;
        result.frame_index   = sel_ext[LPR_FIDX_W-1:0];
        result.evicted_valid = ev_valid_reg;
        result.evicted_page  = ev_valid_reg ? vic_page_ext[LPR_PAGE_W-1:0] : '0;
        result.fault_count   = faults_reg;
    end

    assign status.idle      = (state_reg == ST_IDLE);
    assign status.res_valid = (state_reg == ST_DONE);

endmodule

FILE: rtl/lru_page_replacement_top.sv
// Top level of the LRU page replacement block: stream ports and result register.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+----------------------------------
//   s_       | in        | s_tvalid / s_tready  | tdata page_number, tuser first_ref
//   m_       | out       | m_tvalid / m_tready  | tdata hit..fault_count
//   cfg_     | in        | cfg_valid / cfg_ready| cfg_data frames_in_use
//
// Each reference makes two passes over the N active entries of the frame table,
// N the active frame count: one pass to search and one pass to write back the
// ranks, one table entry per cycle through the single read port of the memory.
// Reset is synchronous, active low, and empties all frames; frames_in_use
// returns to 3. A stalled m_ side holds the last result while the next
// reference is taken; the sequencer waits only if a second result is ready.
module lru_page_replacement_top import lpr_pkg::*; #(
    parameter int MAX_FRAMES = LPR_MAX_FRAMES,
    parameter int PAGE_BITS  = LPR_PAGE_BITS
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // s_tdata: [15:0] page_number
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [LPR_PAGE_W-1:0]   s_tdata,
    // s_tuser: [0] first_ref
    input  logic                    s_tuser,
    // m_tdata: [0] hit, [3:1] frame_index, [4] evicted_valid,
    //          [20:5] evicted_page, [52:21] fault_count, [55:53] zero
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [LPR_M_DATA_W-1:0] m_tdata,
    // cfg_data: [3:0] frames_in_use
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [LPR_FRAMES_W-1:0] cfg_data
);

    localparam int IDX_W   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int ENTRY_W = IDX_W + PAGE_BITS;

    logic [LPR_FRAMES_W-1:0] frames_reg, frames_next;
    logic                    m_valid_reg, m_valid_next;
    lpr_result_t             m_res_reg, m_res_next;

    lpr_status_t             status;
    lpr_result_t             result;
    logic                    s_accept;
    logic                    res_ready;
    logic                    mem_rd_en;
    logic [IDX_W-1:0]        mem_rd_addr;
    logic [ENTRY_W-1:0]      mem_rdata;
    logic                    mem_wr_en;
    logic [IDX_W-1:0]        mem_wr_addr;
    logic [ENTRY_W-1:0]      mem_wdata;

    assign s_tready  = status.idle;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign res_ready = !m_valid_reg || m_tready;

    // Frame count register
    always_comb begin
        frames_next = frames_reg;
        if (cfg_valid && cfg_ready) begin
            frames_next = cfg_data;
        end
    end

    // Result register: load when empty or draining, drop when taken
    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (status.res_valid && res_ready) begin
            m_valid_next = 1'b1;
            m_res_next   = result;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frames_reg  <= LPR_FRAMES_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            frames_reg  <= frames_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(LPR_M_DATA_W - LPR_RES_W){1'b0}}, m_res_reg};

    lpr_ctrl #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BITS  (PAGE_BITS),
        .IDX_W      (IDX_W),
        .ENTRY_W    (ENTRY_W)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .start         (s_accept),
        .start_page    (s_tdata),
        .start_first   (s_tuser),
        .frames_in_use (frames_reg),
        .status        (status),
        .res_ready     (res_ready),
        .result        (result),
        .mem_rd_en     (mem_rd_en),
        .mem_rd_addr   (mem_rd_addr),
        .mem_rdata     (mem_rdata),
        .mem_wr_en     (mem_wr_en),
        .mem_wr_addr   (mem_wr_addr),
        .mem_wdata     (mem_wdata)
    );

    lpr_frame_mem #(
        .DEPTH  (MAX_FRAMES),
        .ADDR_W (IDX_W),
        .DATA_W (ENTRY_W)
    ) u_frame_mem (
        .aclk    (aclk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rdata),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wdata)
    );

    // A taken reference blocks further input until its result is passed on
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_tready && !status.res_valid ##1 !status.res_valid)
        else $error("sequencer free too soon after a reference");

    // A fault always leaves a nonzero fault count
    a_fault_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_res_reg.hit |-> m_res_reg.fault_count != '0)
        else $error("fault result with zero fault count");

    // Only a fault can evict a page
    a_evict_on_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        status.res_valid && result.evicted_valid |-> !result.hit)
        else $error("eviction reported on a hit");

    // Table writes happen only in the write-back pass, never with a read at the same entry
    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_wr_en && mem_rd_en |-> mem_wr_addr != mem_rd_addr)
        else $error("frame table read and write collide");

endmodule
